### sv/assert_macros.svh
// assertion macros used by the checker file
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/fsa_pkg.sv
`timescale 1ns / 1ps
// types and constants of the fragment slot allocator
// no dependencies
package fsa_pkg;

  localparam logic REQ_CREATE = 1'b0;
  localparam logic REQ_APPEND = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // bytes in front of the payload of each fragment
  localparam int FRAG_HEADER = 2;

  typedef struct packed {
    logic        req_type;
    logic [19:0] file_size;
    logic [7:0]  cur_frag;
    logic [7:0]  frag_num;
  } fsa_in_t;

  typedef struct packed {
    logic        status;
    logic [7:0]  frag_out;
    logic [11:0] index_out;
    logic [15:0] node_id;
    logic [7:0]  start_frag;
    logic [7:0]  frag_num_out;
    logic        linked;
  } fsa_out_t;

endpackage

### sv/fragment_slot_allocator_core.sv
`timescale 1ns / 1ps
// fragment slot allocator: create-node and append-byte requests
// depends on fsa_pkg
//
// Each request runs in two steps: one captures the request while the node
// count memory is read at the open fragment, one computes, writes back the
// memory and loads the result register. The next request is taken while a
// result still waits for the output side. Free fragments pop in ascending
// order, so the free list is a counter. At most one fragment is partly full
// at a time; its id is held in a register and its node count in a
// synchronous memory. Links are written to a separate memory. No clearing
// pass is needed after reset.
module fragment_slot_allocator_core #(
  parameter int NUM_FRAGS      = 256,
  parameter int SLOTS_PER_FRAG = 32,
  parameter int FRAG_PAYLOAD   = 4090
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  fsa_pkg::fsa_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output fsa_pkg::fsa_out_t out_data
);
  import fsa_pkg::*;

  localparam int FW = $clog2(NUM_FRAGS);
  localparam int CW = $clog2(SLOTS_PER_FRAG + 1);
  localparam logic [FW:0] NF = NUM_FRAGS[FW:0];

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic          state_r, state_nxt;
  fsa_in_t       req_r;
  logic [FW:0]   stack_count_r, stack_count_nxt;
  logic          open_vld_r, open_vld_nxt;
  logic [FW-1:0] open_frag_r, open_frag_nxt;
  logic [15:0]   node_counter_r, node_counter_nxt;
  logic          out_valid_r, out_valid_nxt;
  fsa_out_t      out_r, res;

  logic [CW-1:0] cnt_mem [NUM_FRAGS];
  logic [CW-1:0] cnt_rdata_r;
  logic          cnt_we;
  logic [FW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata;

  logic [FW-1:0] next_mem [NUM_FRAGS];
  logic          lnk_we;
  logic [FW-1:0] lnk_waddr;

  logic          accept, commit;
  logic [FW:0]   pop0, pop1;
  logic [23:0]   prod;
  logic signed [25:0] diff;
  logic [19:0]   off;
  logic          full;
  logic [16:0]   cur_ext;
  logic [CW-1:0] new_cnt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign commit   = (state_r == S_RUN) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign pop0    = NF - stack_count_r;
  assign pop1    = pop0 + 1'b1;
  assign prod    = 24'(req_r.frag_num) * 24'(FRAG_PAYLOAD);
  assign diff    = $signed({6'b0, req_r.file_size}) - $signed({2'b0, prod});
  assign off     = diff[25] ? '0 : diff[19:0];
  assign full    = off >= 20'(FRAG_PAYLOAD);
  assign cur_ext = 17'(req_r.cur_frag);

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rdata_r <= cnt_mem[open_frag_r];
  end

  always_ff @(posedge clk) begin
    if (lnk_we) begin
      next_mem[lnk_waddr] <= pop0[FW-1:0];
    end
  end

  always_comb begin
    res              = '0;
    stack_count_nxt  = stack_count_r;
    open_vld_nxt     = open_vld_r;
    open_frag_nxt    = open_frag_r;
    node_counter_nxt = node_counter_r;
    cnt_we           = 1'b0;
    cnt_waddr        = open_frag_r;
    cnt_wdata        = '0;
    new_cnt          = '0;
    lnk_we           = 1'b0;
    lnk_waddr        = cur_ext[FW-1:0];
    if (req_r.req_type == REQ_CREATE) begin
      if (stack_count_r == '0 || (!open_vld_r && stack_count_r == (FW+1)'(1))) begin
        res.status = STATUS_EMPTY;
      end else if (open_vld_r) begin
        new_cnt          = cnt_rdata_r + 1'b1;
        res.frag_out     = 8'(open_frag_r);
        res.index_out    = 12'(cnt_rdata_r);
        res.start_frag   = 8'(pop0);
        stack_count_nxt  = stack_count_r - 1'b1;
      end else begin
        new_cnt          = CW'(1);
        res.frag_out     = 8'(pop0);
        res.start_frag   = 8'(pop1);
        open_frag_nxt    = pop0[FW-1:0];
        stack_count_nxt  = stack_count_r - (FW+1)'(2);
      end
      if (res.status == STATUS_OK) begin
        res.node_id      = node_counter_r;
        node_counter_nxt = node_counter_r + 1'b1;
        cnt_we           = commit;
        cnt_waddr        = open_frag_nxt;
        cnt_wdata        = new_cnt;
        open_vld_nxt     = new_cnt < CW'(SLOTS_PER_FRAG);
      end
    end else begin
      res.frag_out     = req_r.cur_frag;
      res.frag_num_out = req_r.frag_num;
      if (!full) begin
        res.index_out = 12'(off + 20'(FRAG_HEADER));
      end else if (stack_count_r == '0) begin
        res.status = STATUS_EMPTY;
      end else begin
        res.frag_out     = 8'(pop0);
        res.index_out    = 12'(FRAG_HEADER);
        res.frag_num_out = req_r.frag_num + 8'd1;
        res.linked       = 1'b1;
        stack_count_nxt  = stack_count_r - 1'b1;
        lnk_we           = commit && (cur_ext < 17'(NUM_FRAGS));
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        if (commit) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      stack_count_r  <= NF;
      open_vld_r     <= 1'b0;
      open_frag_r    <= '0;
      node_counter_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        stack_count_r  <= stack_count_nxt;
        open_vld_r     <= open_vld_nxt;
        open_frag_r    <= open_frag_nxt;
        node_counter_r <= node_counter_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (commit) begin
      out_r <= res;
    end
  end

endmodule

### sv/fsa_checker.sv
`timescale 1ns / 1ps
// port-level checks on the fragment slot allocator
// depends on fsa_pkg and assert_macros.svh
`include "assert_macros.svh"

module fsa_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input fsa_pkg::fsa_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input fsa_pkg::fsa_out_t out_data
);
  import fsa_pkg::*;

  // a stalled request holds
  `CHK_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_data))
  // a stalled result holds
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
  // a chained fragment always starts at the payload head
  `CHK_IMPL(a_link_head, out_valid && out_data.linked,
            out_data.status == STATUS_OK && out_data.index_out == 12'(FRAG_HEADER))
  // a failed request never reports a link
  `CHK_IMPL(a_fail_nolink, out_valid && out_data.status == STATUS_EMPTY, !out_data.linked)
  // an accepted request blocks the input side for the next cycle
  `CHK_NEXT(a_one_busy, in_valid && !in_stall, in_stall)

endmodule

bind fragment_slot_allocator_core fsa_checker u_fsa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
